>>> rtl/vps_pkg.sv
// ----------------------------------------------------------------------------
// vps_pkg: shared types and constants of the Verlet particle block
// Field widths, register indexes, reset values and the 16-bit saturator.
// ----------------------------------------------------------------------------
package vps_pkg;

	localparam int IDX_W      = 6;
	localparam int POS_W      = 16;
	localparam int DT_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int PR_W       = 13;
	localparam int BR_W       = 15;
	localparam int SAT_W      = 40;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_X  = 3'd0,
		REG_ACCEL_Y  = 3'd1,
		REG_PART_RAD = 3'd2,
		REG_CENTER_X = 3'd3,
		REG_CENTER_Y = 3'd4,
		REG_BOUND    = 3'd5
	} cfg_reg_t;

	localparam logic signed [POS_W-1:0] RST_ACCEL_X  = 16'sd0;
	localparam logic signed [POS_W-1:0] RST_ACCEL_Y  = 16'sd256;
	localparam logic [PR_W-1:0]         RST_PART_RAD = 13'd512;
	localparam logic signed [POS_W-1:0] RST_CENTER_X = 16'sd11520;
	localparam logic signed [POS_W-1:0] RST_CENTER_Y = 16'sd5120;
	localparam logic [BR_W-1:0]         RST_BOUND    = 15'd5120;

	// clamp a wide signed value to the Q8.8 range
	function automatic logic signed [POS_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
		if (v > 40'sd32767) begin
			return 16'sh7fff;
		end else if (v < -40'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[POS_W-1:0];
		end
	endfunction

endpackage

>>> rtl/vps_req_if.sv
// ----------------------------------------------------------------------------
// vps_req_if: input channel of the Verlet particle block
// Valid/ready beat carrying one load or frame item.
// ----------------------------------------------------------------------------
interface vps_req_if;
	import vps_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    op;
	logic [IDX_W-1:0]        index;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic [DT_W-1:0]         dt;

	modport source(output valid, op, index, pos_x, pos_y, dt, input ready);
	modport sink(input valid, op, index, pos_x, pos_y, dt, output ready);
endinterface

>>> rtl/vps_res_if.sv
// ----------------------------------------------------------------------------
// vps_res_if: result channel of the Verlet particle block
// Valid/ready beat carrying one particle position.
// ----------------------------------------------------------------------------
interface vps_res_if;
	import vps_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        index_res;
	logic signed [POS_W-1:0] pos_x_res;
	logic signed [POS_W-1:0] pos_y_res;
	logic                    last;

	modport source(output valid, index_res, pos_x_res, pos_y_res, last, input ready);
	modport sink(input valid, index_res, pos_x_res, pos_y_res, last, output ready);
endinterface

>>> rtl/vps_ram.sv
// ----------------------------------------------------------------------------
// vps_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/verlet_particle_step.sv
// ----------------------------------------------------------------------------
// verlet_particle_step: Verlet particle integrator with circular bound
// Particle positions in two RAMs, one sequencer with shared square root
// and twin dividers doing collisions, Verlet steps and bound pull-back.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per beat. A load item (op = 0) writes both the
//   current and previous position of one particle and gives no result; an
//   index at or beyond MAX_PARTICLES is dropped. A frame item (op = 1)
//   carries dt and produces MAX_PARTICLES beats on res, particle 0 first,
//   last set on the final one.
//   A load is written as it is accepted. A frame walks every pair i<j: a pair
//   that does not overlap is read, squared and compared, one that does also
//   runs the 17-step square root, then the 35-step divide, one quotient bit a
//   cycle, and is written back. Each particle then takes its step and
//   pull-back, then its beat on res. All of it runs through the single read
//   port of each RAM, so req is held off until the last beat of a frame has
//   been taken. While res is stalled the sequencer holds on the waiting beat.
//   Reset restores control and config registers to defaults, marks every RAM
//   entry as unwritten; an unwritten entry reads as zero, so no clearing pass.
//   Configuration writes go on cfg_we/cfg_idx/cfg_wdata while idle.
// ----------------------------------------------------------------------------
module verlet_particle_step #(
	parameter int MAX_PARTICLES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [vps_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [vps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	vps_req_if.sink                          req,
	vps_res_if.source                        res
);
	import vps_pkg::*;

	localparam int AW        = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int SQ_STEPS  = 17;
	localparam int DIV_STEPS = 35;
	localparam logic [AW-1:0] LAST = AW'(MAX_PARTICLES - 1);

	typedef enum logic [21:0] {
		S_IDLE    = 22'h000001,
		S_DT2     = 22'h000002,
		S_ACC_MUL = 22'h000004,
		S_ACC_FIN = 22'h000008,
		S_C_RDI   = 22'h000010,
		S_C_RDJ   = 22'h000020,
		S_C_DIFF  = 22'h000040,
		S_SQ      = 22'h000080,
		S_CMP     = 22'h000100,
		S_SQRT    = 22'h000200,
		S_C_PEN   = 22'h000400,
		S_A_CHK   = 22'h000800,
		S_MUL     = 22'h001000,
		S_DINIT   = 22'h002000,
		S_DIV     = 22'h004000,
		S_C_WI    = 22'h008000,
		S_C_WJ    = 22'h010000,
		S_A_RD    = 22'h020000,
		S_A_NEW   = 22'h040000,
		S_A_DIFF  = 22'h080000,
		S_A_FIN   = 22'h100000,
		S_OUT     = 22'h200000
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [POS_W-1:0] ax_q, ay_q, cx_q, cy_q;
	logic [PR_W-1:0]         pr_q;
	logic [BR_W-1:0]         br_q;

	// frame constants
	logic [DT_W-1:0]         dt_q;
	logic [31:0]             dt2_q;
	logic [PR_W:0]           sr_q;
	logic [27:0]             sr2_q;
	logic                    acc_y_q;
	logic [31:0]             ph_q, pl_q;
	logic                    acc_neg_q;
	logic signed [17:0]      tx_q, ty_q;

	// loop counters and mode (0 collide, 1 advance)
	logic [AW-1:0]           i_q, j_q, k_q;
	logic                    adv_q;

	// datapath
	logic signed [POS_W-1:0] cix_q, ciy_q, cjx_q, cjy_q, nx_q, ny_q;
	logic signed [16:0]      dx_q, dy_q;
	logic [32:0]             sqx_q, sqy_q;
	logic signed [17:0]      mfac_q;
	logic [16:0]             div_d_q;
	logic signed [34:0]      prx_q, pry_q;

	// square root unit
	logic [33:0]             sq_v_q;
	logic [19:0]             sq_rem_q;
	logic [16:0]             sq_root_q;
	logic [5:0]              cnt_q;

	// twin dividers
	logic [34:0]             dvx_q, dvy_q;
	logic [17:0]             remx_q, remy_q;
	logic                    negx_q, negy_q;

	// result register
	logic [IDX_W-1:0]        ores_idx_q;
	logic signed [POS_W-1:0] ores_x_q, ores_y_q;
	logic                    ores_last_q;

	// RAM ports and written marks
	logic                    cur_we, prv_we;
	logic [AW-1:0]           cur_waddr, prv_waddr, cur_raddr, prv_raddr;
	logic [31:0]             cur_wdata, prv_wdata, cur_rdata, prv_rdata;
	logic [MAX_PARTICLES-1:0] cur_vld_q, prv_vld_q;
	logic                    cur_rvld_q, prv_rvld_q;

	logic [31:0]             cur_rd, prv_rd;
	logic signed [POS_W-1:0] crx, cry, prx_v, pry_v;
	logic                    load_ok;
	logic [33:0]             d2;
	logic signed [35:0]      qx, qy;
	logic [19:0]             sq_remn, sq_trial;
	logic [17:0]             remxn, remyn, div_dx;
	logic [15:0]             acc_mag;
	logic [48:0]             acc_sum;
	logic [16:0]             acc_t;
	logic                    pair_done, pair_end;
	logic signed [POS_W-1:0] wix, wiy, wjx, wjy, fx, fy, nxv, nyv;

	vps_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_cur_ram (
		.clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
		.raddr(cur_raddr), .rdata(cur_rdata)
	);

	vps_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_prv_ram (
		.clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.raddr(prv_raddr), .rdata(prv_rdata)
	);

	// an entry never written reads as zero
	assign cur_rd = cur_rvld_q ? cur_rdata : 32'd0;
	assign prv_rd = prv_rvld_q ? prv_rdata : 32'd0;
	assign crx    = cur_rd[31:16];
	assign cry    = cur_rd[15:0];
	assign prx_v  = prv_rd[31:16];
	assign pry_v  = prv_rd[15:0];

	assign req.ready = (state_q == S_IDLE);
	assign load_ok   = ({1'b0, req.index} < 7'(MAX_PARTICLES));

	// quotients with sign restored
	assign qx = negx_q ? -$signed({1'b0, dvx_q}) : $signed({1'b0, dvx_q});
	assign qy = negy_q ? -$signed({1'b0, dvy_q}) : $signed({1'b0, dvy_q});

	// collision updates: i gains the offset, j loses it
	assign wix = sat16(SAT_W'(cix_q) + SAT_W'(qx));
	assign wiy = sat16(SAT_W'(ciy_q) + SAT_W'(qy));
	assign wjx = sat16(SAT_W'(cjx_q) - SAT_W'(qx));
	assign wjy = sat16(SAT_W'(cjy_q) - SAT_W'(qy));
	// pull-back toward the bound centre
	assign fx  = sat16(SAT_W'(nx_q) - SAT_W'(qx));
	assign fy  = sat16(SAT_W'(ny_q) - SAT_W'(qy));
	// Verlet position: 2*cur - prev + acceleration term
	assign nxv = sat16(SAT_W'(crx) + SAT_W'(crx) - SAT_W'(prx_v) + SAT_W'(tx_q));
	assign nyv = sat16(SAT_W'(cry) + SAT_W'(cry) - SAT_W'(pry_v) + SAT_W'(ty_q));

	assign d2 = {1'b0, sqx_q} + {1'b0, sqy_q};

	// one root bit per step
	assign sq_remn  = {sq_rem_q[17:0], sq_v_q[33:32]};
	assign sq_trial = {1'b0, sq_root_q, 2'b01};

	// one quotient bit per step on each axis
	assign div_dx = {1'b0, div_d_q};
	assign remxn  = {remx_q[16:0], dvx_q[34]};
	assign remyn  = {remy_q[16:0], dvy_q[34]};

	// rounded acceleration term, half away from zero
	assign acc_mag = acc_y_q ? (ay_q[15] ? 16'(-ay_q) : ay_q) : (ax_q[15] ? 16'(-ax_q) : ax_q);
	assign acc_sum = {1'b0, ph_q, 16'd0} + {17'd0, pl_q} + 49'h0_0000_8000_0000;
	assign acc_t   = acc_sum[48:32];

	assign pair_done = (j_q == LAST);
	assign pair_end  = pair_done && (i_q == LAST - AW'(1));

	// RAM access per state
	always_comb begin
		cur_we    = 1'b0;
		cur_waddr = k_q;
		cur_wdata = {ores_x_q, ores_y_q};
		prv_we    = 1'b0;
		prv_waddr = k_q;
		prv_wdata = cur_rd;
		cur_raddr = k_q;
		prv_raddr = k_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid && req.op == OP_LOAD && load_ok) begin
					cur_we    = 1'b1;
					prv_we    = 1'b1;
					cur_waddr = req.index[AW-1:0];
					prv_waddr = req.index[AW-1:0];
					cur_wdata = {req.pos_x, req.pos_y};
					prv_wdata = {req.pos_x, req.pos_y};
				end
			end
			S_C_RDI: cur_raddr = i_q;
			S_C_RDJ: cur_raddr = j_q;
			S_C_WI: begin
				cur_we    = 1'b1;
				cur_waddr = i_q;
				cur_wdata = {wix, wiy};
			end
			S_C_WJ: begin
				cur_we    = 1'b1;
				cur_waddr = j_q;
				cur_wdata = {wjx, wjy};
			end
			S_A_NEW: prv_we = 1'b1;
			S_A_FIN: begin
				cur_we    = 1'b1;
				cur_wdata = {fx, fy};
			end
			default: ;
		endcase
	end

	// written marks and read-side capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q  <= '0;
			prv_vld_q  <= '0;
			cur_rvld_q <= 1'b0;
			prv_rvld_q <= 1'b0;
		end else begin
			if (cur_we) begin
				cur_vld_q[cur_waddr] <= 1'b1;
			end
			if (prv_we) begin
				prv_vld_q[prv_waddr] <= 1'b1;
			end
			cur_rvld_q <= cur_vld_q[cur_raddr];
			prv_rvld_q <= prv_vld_q[prv_raddr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= RST_ACCEL_X;
			ay_q <= RST_ACCEL_Y;
			pr_q <= RST_PART_RAD;
			cx_q <= RST_CENTER_X;
			cy_q <= RST_CENTER_Y;
			br_q <= RST_BOUND;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ACCEL_X:  ax_q <= cfg_wdata;
				REG_ACCEL_Y:  ay_q <= cfg_wdata;
				REG_PART_RAD: pr_q <= cfg_wdata[PR_W-1:0];
				REG_CENTER_X: cx_q <= cfg_wdata;
				REG_CENTER_Y: cy_q <= cfg_wdata;
				REG_BOUND:    br_q <= cfg_wdata[BR_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			adv_q   <= 1'b0;
			acc_y_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.op == OP_FRAME) begin
						state_q <= S_DT2;
					end
				end
				S_DT2: begin
					acc_y_q <= 1'b0;
					state_q <= S_ACC_MUL;
				end
				S_ACC_MUL: state_q <= S_ACC_FIN;
				S_ACC_FIN: begin
					if (!acc_y_q) begin
						acc_y_q <= 1'b1;
						state_q <= S_ACC_MUL;
					end else begin
						i_q     <= '0;
						j_q     <= AW'(1);
						adv_q   <= 1'b0;
						state_q <= S_C_RDI;
					end
				end
				S_C_RDI:  state_q <= S_C_RDJ;
				S_C_RDJ:  state_q <= S_C_DIFF;
				S_C_DIFF: state_q <= S_SQ;
				S_SQ:     state_q <= S_CMP;
				S_CMP: begin
					cnt_q <= '0;
					if (adv_q) begin
						state_q <= (d2 == 34'd0) ? S_A_FIN : S_SQRT;
					end else if (d2 == 34'd0 || d2 >= {6'd0, sr2_q}) begin
						// no contact: move to the next pair
						if (pair_end) begin
							k_q     <= '0;
							adv_q   <= 1'b1;
							state_q <= S_A_RD;
						end else if (pair_done) begin
							i_q     <= i_q + AW'(1);
							j_q     <= i_q + AW'(2);
							state_q <= S_C_RDI;
						end else begin
							j_q     <= j_q + AW'(1);
							state_q <= S_C_RDI;
						end
					end else begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(SQ_STEPS - 1)) begin
						state_q <= adv_q ? S_A_CHK : S_C_PEN;
					end
				end
				S_C_PEN: state_q <= S_MUL;
				S_A_CHK: begin
					if ({1'b0, sq_root_q} + 18'(pr_q) > 18'(br_q)) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_A_FIN;
					end
				end
				S_MUL: state_q <= S_DINIT;
				S_DINIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DIV_STEPS - 1)) begin
						state_q <= adv_q ? S_A_FIN : S_C_WI;
					end
				end
				S_C_WI: state_q <= S_C_WJ;
				S_C_WJ: begin
					if (pair_end) begin
						k_q     <= '0;
						adv_q   <= 1'b1;
						state_q <= S_A_RD;
					end else if (pair_done) begin
						i_q     <= i_q + AW'(1);
						j_q     <= i_q + AW'(2);
						state_q <= S_C_RDI;
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= S_C_RDI;
					end
				end
				S_A_RD:   state_q <= S_A_NEW;
				S_A_NEW:  state_q <= S_A_DIFF;
				S_A_DIFF: state_q <= S_SQ;
				S_A_FIN:  state_q <= S_OUT;
				S_OUT: begin
					// hold the beat until the receiver takes it
					if (res.ready) begin
						if (k_q == LAST) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_A_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: dt_q <= req.dt;
			S_DT2: begin
				dt2_q <= dt_q * dt_q;
				sr_q  <= {pr_q, 1'b0};
				sr2_q <= {pr_q, 1'b0} * {pr_q, 1'b0};
			end
			S_ACC_MUL: begin
				ph_q      <= acc_mag * dt2_q[31:16];
				pl_q      <= acc_mag * dt2_q[15:0];
				acc_neg_q <= acc_y_q ? ay_q[15] : ax_q[15];
			end
			S_ACC_FIN: begin
				if (!acc_y_q) begin
					tx_q <= acc_neg_q ? -$signed({1'b0, acc_t}) : $signed({1'b0, acc_t});
				end else begin
					ty_q <= acc_neg_q ? -$signed({1'b0, acc_t}) : $signed({1'b0, acc_t});
				end
			end
			S_C_RDJ: begin
				cix_q <= crx;
				ciy_q <= cry;
			end
			S_C_DIFF: begin
				cjx_q <= crx;
				cjy_q <= cry;
				dx_q  <= {cix_q[15], cix_q} - {crx[15], crx};
				dy_q  <= {ciy_q[15], ciy_q} - {cry[15], cry};
			end
			S_SQ: begin
				sqx_q <= 33'(dx_q * dx_q);
				sqy_q <= 33'(dy_q * dy_q);
			end
			S_CMP: begin
				sq_v_q    <= d2;
				sq_rem_q  <= '0;
				sq_root_q <= '0;
				dvx_q     <= '0;
				dvy_q     <= '0;
				negx_q    <= 1'b0;
				negy_q    <= 1'b0;
			end
			S_SQRT: begin
				sq_v_q <= {sq_v_q[31:0], 2'b00};
				if (sq_remn >= sq_trial) begin
					sq_rem_q  <= sq_remn - sq_trial;
					sq_root_q <= {sq_root_q[15:0], 1'b1};
				end else begin
					sq_rem_q  <= sq_remn;
					sq_root_q <= {sq_root_q[15:0], 1'b0};
				end
			end
			S_C_PEN: begin
				// half the penetration over the distance: pen / (2*dist)
				mfac_q  <= $signed({4'd0, sr_q}) - $signed({1'b0, sq_root_q});
				div_d_q <= {sq_root_q[15:0], 1'b0};
			end
			S_A_CHK: begin
				mfac_q  <= $signed({1'b0, sq_root_q}) - $signed({3'd0, br_q});
				div_d_q <= sq_root_q;
			end
			S_MUL: begin
				prx_q <= dx_q * mfac_q;
				pry_q <= dy_q * mfac_q;
			end
			S_DINIT: begin
				negx_q <= prx_q[34];
				negy_q <= pry_q[34];
				dvx_q  <= prx_q[34] ? 35'(-prx_q) : 35'(prx_q);
				dvy_q  <= pry_q[34] ? 35'(-pry_q) : 35'(pry_q);
				remx_q <= '0;
				remy_q <= '0;
			end
			S_DIV: begin
				if (remxn >= div_dx) begin
					remx_q <= remxn - div_dx;
					dvx_q  <= {dvx_q[33:0], 1'b1};
				end else begin
					remx_q <= remxn;
					dvx_q  <= {dvx_q[33:0], 1'b0};
				end
				if (remyn >= div_dx) begin
					remy_q <= remyn - div_dx;
					dvy_q  <= {dvy_q[33:0], 1'b1};
				end else begin
					remy_q <= remyn;
					dvy_q  <= {dvy_q[33:0], 1'b0};
				end
			end
			S_A_NEW: begin
				nx_q <= nxv;
				ny_q <= nyv;
			end
			S_A_DIFF: begin
				dx_q <= {nx_q[15], nx_q} - {cx_q[15], cx_q};
				dy_q <= {ny_q[15], ny_q} - {cy_q[15], cy_q};
			end
			S_A_FIN: begin
				ores_idx_q  <= IDX_W'(k_q);
				ores_x_q    <= fx;
				ores_y_q    <= fy;
				ores_last_q <= (k_q == LAST);
			end
			default: ;
		endcase
		// skip the pull-back: leave a zero quotient
		if (state_q == S_A_CHK && !({1'b0, sq_root_q} + 18'(pr_q) > 18'(br_q))) begin
			dvx_q  <= '0;
			dvy_q  <= '0;
			negx_q <= 1'b0;
			negy_q <= 1'b0;
		end
	end

	assign res.valid     = (state_q == S_OUT);
	assign res.index_res = ores_idx_q;
	assign res.pos_x_res = ores_x_q;
	assign res.pos_y_res = ores_y_q;
	assign res.last      = ores_last_q;

	// a result beat never names a particle beyond the store
	a_res_index: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ({1'b0, res.index_res} < 7'(MAX_PARTICLES)))
		else $error("result index beyond particle count");

	// the block never takes an item while a result beat is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && res.valid))
		else $error("input accepted during a frame");

	// taking the last beat of a frame returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && res.last) |=> req.ready)
		else $error("block not idle after last beat");

	// a taken non-last beat is not shown again straight away: valid drops after it
	a_res_order: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && !res.last) |=> !res.valid)
		else $error("result beat repeated");
endmodule
